// ----- design/i2cms_pkg.sv -----
`default_nettype none

package i2cms_pkg;

    // Buffer and count sizing
    localparam int SEND_DEPTH = 16;
    localparam int READ_MAX   = 16;
    localparam int COUNT_W    = 5;
    localparam int SEND_IDX_W = $clog2(SEND_DEPTH);
    localparam int READ_IDX_W = 4;

    // Command codes
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_EVENT = 2'd2
    } command_t;

    // Start modes
    typedef enum logic [1:0] {
        MODE_WRITE        = 2'd0,
        MODE_WRITE_READ   = 2'd1,
        MODE_READ         = 2'd2,
        MODE_WRITE_RSTART = 2'd3
    } mode_t;

    // Bus actions
    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_SEND  = 3'd2,
        ACT_STOP  = 3'd3,
        ACT_RXEN  = 3'd4,
        ACT_ACK   = 3'd5,
        ACT_NACK  = 3'd6
    } action_t;

    // Transaction status
    typedef enum logic [1:0] {
        ST_SUCCESS = 2'd0,
        ST_PENDING = 2'd1,
        ST_FAILED  = 2'd2
    } status_t;

    // One incoming transaction
    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         mode;
        logic [6:0]         device_address;
        logic [7:0]         register_address;
        logic [COUNT_W-1:0] write_count;
        logic [COUNT_W-1:0] read_count;
        logic [3:0]         load_index;
        logic [7:0]         load_byte;
        logic               ack_seen;
        logic               collision;
        logic [7:0]         bus_byte;
    } item_t;

    // One result transaction
    typedef struct packed {
        logic                  start_accepted;
        logic [2:0]            bus_action;
        logic [7:0]            send_byte;
        logic                  read_valid;
        logic [7:0]            read_byte;
        logic [READ_IDX_W-1:0] read_index;
        logic [1:0]            status;
    } result_t;

endpackage

`default_nettype wire

// ----- design/i2cms_in_stage.sv -----
`default_nettype none

module i2cms_in_stage
    import i2cms_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire item_t in_item,
    input  wire logic  advance,
    output logic       held_valid,
    output item_t      held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // Stall only while a held transaction cannot move on
    assign in_stall   = valid_reg && !advance;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept ? 1'b1 : (advance ? 1'b0 : valid_reg);

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

`default_nettype wire

// ----- design/i2cms_core.sv -----
`default_nettype none

module i2cms_core
    import i2cms_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  advance,
    input  wire item_t item,
    output result_t    result
);

    typedef enum logic [3:0] {
        PH_SUCCESS  = 4'd0,
        PH_FAIL     = 4'd1,
        PH_ADDR     = 4'd2,
        PH_REG      = 4'd3,
        PH_DATA     = 4'd4,
        PH_RESTART  = 4'd5,
        PH_RDREQ    = 4'd6,
        PH_FIRSTRX  = 4'd7,
        PH_RXBYTE   = 4'd8,
        PH_RXEN     = 4'd9,
        PH_LASTSTOP = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        TM_PLAIN       = 2'd0,
        TM_WRITE_READ  = 2'd1,
        TM_WRITE_WRITE = 2'd2
    } xfer_mode_t;

    localparam logic [COUNT_W-1:0] SEND_DEPTH_C = COUNT_W'(SEND_DEPTH);
    localparam logic [COUNT_W-1:0] READ_MAX_C   = COUNT_W'(READ_MAX);

    phase_t             phase_reg, phase_next;
    status_t            status_reg, status_next;
    logic               dir_read_reg, dir_read_next;
    xfer_mode_t         xfer_mode_reg, xfer_mode_next;
    logic [7:0]         address_byte_reg, address_byte_next;
    logic [7:0]         register_byte_reg, register_byte_next;
    logic [COUNT_W-1:0] send_total_reg, send_total_next;
    logic [COUNT_W-1:0] send_pos_reg, send_pos_next;
    logic [COUNT_W-1:0] read_total_reg, read_total_next;
    logic [COUNT_W-1:0] read_pos_reg, read_pos_next;
    logic [7:0]         send_buffer_reg [SEND_DEPTH];

    logic               load_en;
    logic [COUNT_W-1:0] write_sat;
    logic [COUNT_W-1:0] read_min1;
    logic [COUNT_W-1:0] read_sat;
    logic [COUNT_W-1:0] read_pos_inc;
    logic [7:0]         buffer_byte;
    action_t            action;

    // Saturate the start counts
    assign write_sat    = (item.write_count > SEND_DEPTH_C) ? SEND_DEPTH_C : item.write_count;
    assign read_min1    = (item.read_count == '0) ? COUNT_W'(1) : item.read_count;
    assign read_sat     = (read_min1 > READ_MAX_C) ? READ_MAX_C : read_min1;
    assign read_pos_inc = read_pos_reg + COUNT_W'(1);
    assign buffer_byte  = send_buffer_reg[send_pos_reg[SEND_IDX_W-1:0]];
    assign load_en      = advance && (command_t'(item.command) == CMD_LOAD)
                          && (32'(item.load_index) < SEND_DEPTH);

    // Step the phase machine for one transaction
    always_comb
    begin
        phase_next         = phase_reg;
        status_next        = status_reg;
        dir_read_next      = dir_read_reg;
        xfer_mode_next     = xfer_mode_reg;
        address_byte_next  = address_byte_reg;
        register_byte_next = register_byte_reg;
        send_total_next    = send_total_reg;
        send_pos_next      = send_pos_reg;
        read_total_next    = read_total_reg;
        read_pos_next      = read_pos_reg;
        action             = ACT_NONE;
        result             = '0;

        case (command_t'(item.command))
            CMD_START:
            begin
                if (status_reg != ST_PENDING)
                begin
                    result.start_accepted = 1'b1;
                    action             = ACT_START;
                    address_byte_next  = {item.device_address, 1'b0};
                    register_byte_next = item.register_address;
                    send_total_next    = write_sat;
                    send_pos_next      = '0;
                    read_total_next    = read_sat;
                    read_pos_next      = '0;
                    status_next        = ST_PENDING;
                    phase_next         = PH_ADDR;
                    case (mode_t'(item.mode))
                        MODE_WRITE:
                        begin
                            dir_read_next  = 1'b0;
                            xfer_mode_next = TM_PLAIN;
                        end
                        MODE_WRITE_READ:
                        begin
                            // No payload: run as a plain read
                            if (write_sat == '0)
                            begin
                                dir_read_next  = 1'b1;
                                xfer_mode_next = TM_PLAIN;
                            end
                            else
                            begin
                                dir_read_next  = 1'b0;
                                xfer_mode_next = TM_WRITE_READ;
                            end
                        end
                        MODE_READ:
                        begin
                            dir_read_next  = 1'b1;
                            xfer_mode_next = TM_PLAIN;
                        end
                        default:
                        begin
                            dir_read_next  = 1'b1;
                            xfer_mode_next = TM_WRITE_WRITE;
                        end
                    endcase
                end
            end
            CMD_EVENT:
            begin
                if (item.collision)
                begin
                    action     = ACT_STOP;
                    phase_next = PH_FAIL;
                end
                else
                begin
                    case (phase_reg)
                        PH_SUCCESS:
                        begin
                            status_next = ST_SUCCESS;
                        end
                        PH_FAIL:
                        begin
                            status_next = ST_FAILED;
                        end
                        PH_ADDR:
                        begin
                            action           = ACT_SEND;
                            result.send_byte = address_byte_reg;
                            if (xfer_mode_reg == TM_WRITE_WRITE && !dir_read_reg)
                            begin
                                phase_next = PH_DATA;
                            end
                            else
                            begin
                                phase_next = PH_REG;
                            end
                        end
                        PH_REG:
                        begin
                            if (item.ack_seen)
                            begin
                                action           = ACT_SEND;
                                result.send_byte = register_byte_reg;
                                phase_next       = dir_read_reg ? PH_RESTART : PH_DATA;
                            end
                            else
                            begin
                                action     = ACT_STOP;
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_DATA:
                        begin
                            if (!item.ack_seen)
                            begin
                                action     = ACT_STOP;
                                phase_next = PH_FAIL;
                            end
                            else if (send_pos_reg < send_total_reg
                                     && send_pos_reg < SEND_DEPTH_C)
                            begin
                                action           = ACT_SEND;
                                result.send_byte = buffer_byte;
                                send_pos_next    = send_pos_reg + COUNT_W'(1);
                            end
                            else if (xfer_mode_reg == TM_WRITE_READ && !dir_read_reg)
                            begin
                                action        = ACT_START;
                                dir_read_next = 1'b1;
                                phase_next    = PH_RDREQ;
                            end
                            else
                            begin
                                action     = ACT_STOP;
                                phase_next = PH_SUCCESS;
                            end
                        end
                        PH_RESTART:
                        begin
                            action = ACT_START;
                            if (xfer_mode_reg == TM_WRITE_WRITE)
                            begin
                                dir_read_next = 1'b0;
                                phase_next    = PH_ADDR;
                            end
                            else
                            begin
                                phase_next = PH_RDREQ;
                            end
                        end
                        PH_RDREQ:
                        begin
                            action           = ACT_SEND;
                            result.send_byte = address_byte_reg | 8'h01;
                            phase_next       = PH_FIRSTRX;
                        end
                        PH_FIRSTRX:
                        begin
                            if (item.ack_seen)
                            begin
                                action     = ACT_RXEN;
                                phase_next = PH_RXBYTE;
                            end
                            else
                            begin
                                action     = ACT_STOP;
                                phase_next = PH_FAIL;
                            end
                        end
                        PH_RXBYTE:
                        begin
                            // Deliver the byte, then ack or nack the next one
                            result.read_valid = 1'b1;
                            result.read_byte  = item.bus_byte;
                            result.read_index = read_pos_reg[READ_IDX_W-1:0];
                            read_pos_next     = read_pos_inc;
                            if (read_pos_inc < read_total_reg)
                            begin
                                action     = ACT_ACK;
                                phase_next = PH_RXEN;
                            end
                            else
                            begin
                                action     = ACT_NACK;
                                phase_next = PH_LASTSTOP;
                            end
                        end
                        PH_RXEN:
                        begin
                            action     = ACT_RXEN;
                            phase_next = PH_RXBYTE;
                        end
                        PH_LASTSTOP:
                        begin
                            action     = ACT_STOP;
                            phase_next = PH_SUCCESS;
                        end
                        default:
                        begin
                            action     = ACT_STOP;
                            phase_next = PH_FAIL;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase

        result.bus_action = action;
        result.status     = status_next;
    end

    // Hold transaction state; advance on each processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SUCCESS;
            status_reg        <= ST_SUCCESS;
            dir_read_reg      <= 1'b0;
            xfer_mode_reg     <= TM_PLAIN;
            address_byte_reg  <= '0;
            register_byte_reg <= '0;
            send_total_reg    <= '0;
            send_pos_reg      <= '0;
            read_total_reg    <= '0;
            read_pos_reg      <= '0;
        end
        else if (advance)
        begin
            phase_reg         <= phase_next;
            status_reg        <= status_next;
            dir_read_reg      <= dir_read_next;
            xfer_mode_reg     <= xfer_mode_next;
            address_byte_reg  <= address_byte_next;
            register_byte_reg <= register_byte_next;
            send_total_reg    <= send_total_next;
            send_pos_reg      <= send_pos_next;
            read_total_reg    <= read_total_next;
            read_pos_reg      <= read_pos_next;
        end
    end

    // Store loaded payload bytes
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            send_buffer_reg[item.load_index[SEND_IDX_W-1:0]] <= item.load_byte;
        end
    end

endmodule

`default_nettype wire

// ----- design/i2cms_out_stage.sv -----
`default_nettype none

module i2cms_out_stage
    import i2cms_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_result,
    input  wire logic    out_stall,
    output logic         take,
    output logic         out_valid,
    output result_t      out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Free when empty or when the held result leaves now
    assign take       = !valid_reg || !out_stall;
    assign valid_next = load ? 1'b1 : (take ? 1'b0 : valid_reg);

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// ----- design/i2c_master_transaction_sequencer.sv -----
// I2C master register-transaction sequencer. Each input transaction is a start
// command, a transmit-buffer load or a bus-done event, and each gives exactly one
// result transaction naming the next bus action, any received byte with its index,
// and the status after the step. The block takes one transaction per cycle while
// in_stall is low; a result passes from the input register through the single
// step of the phase machine into the result register. Stall on the output backs
// up into in_stall once both registers are full.
`default_nettype none

module i2c_master_transaction_sequencer
    import i2cms_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            command,
    input  wire logic [1:0]            mode,
    input  wire logic [6:0]            device_address,
    input  wire logic [7:0]            register_address,
    input  wire logic [COUNT_W-1:0]    write_count,
    input  wire logic [COUNT_W-1:0]    read_count,
    input  wire logic [3:0]            load_index,
    input  wire logic [7:0]            load_byte,
    input  wire logic                  ack_seen,
    input  wire logic                  collision,
    input  wire logic [7:0]            bus_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       start_accepted,
    output logic [2:0]                 bus_action,
    output logic [7:0]                 send_byte,
    output logic                       read_valid,
    output logic [7:0]                 read_byte,
    output logic [READ_IDX_W-1:0]      read_index,
    output logic [1:0]                 status
);

    item_t   in_item;
    item_t   held_item;
    logic    held_valid;
    logic    take;
    logic    advance;
    result_t step_result;
    result_t out_result;

    // Gather the input fields
    assign in_item = '{
        command:          command,
        mode:             mode,
        device_address:   device_address,
        register_address: register_address,
        write_count:      write_count,
        read_count:       read_count,
        load_index:       load_index,
        load_byte:        load_byte,
        ack_seen:         ack_seen,
        collision:        collision,
        bus_byte:         bus_byte
    };

    // Move a held transaction forward when the result register is free
    assign advance = held_valid && take;

    i2cms_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    i2cms_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (held_item),
        .result  (step_result)
    );

    i2cms_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .load_result (step_result),
        .out_stall   (out_stall),
        .take        (take),
        .out_valid   (out_valid),
        .out_result  (out_result)
    );

    // Drive the result fields
    assign start_accepted = out_result.start_accepted;
    assign bus_action     = out_result.bus_action;
    assign send_byte      = out_result.send_byte;
    assign read_valid     = out_result.read_valid;
    assign read_byte      = out_result.read_byte;
    assign read_index     = out_result.read_index;
    assign status         = out_result.status;

endmodule

`default_nettype wire

// ----- design/i2cms_checker.sv -----
`default_nettype none

module i2cms_checker
    import i2cms_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic                  start_accepted,
    input  wire logic [2:0]            bus_action,
    input  wire logic [7:0]            send_byte,
    input  wire logic                  read_valid,
    input  wire logic [7:0]            read_byte,
    input  wire logic [READ_IDX_W-1:0] read_index,
    input  wire logic [1:0]            status
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bus_action) && $stable(status))
    else $error("stalled result changed");

    // An accepted start issues a start and leaves the transaction pending
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_accepted |-> bus_action == ACT_START && status == ST_PENDING)
    else $error("accepted start without start action or pending status");

    // A transmit byte appears only with a transmit action
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bus_action != ACT_SEND |-> send_byte == 8'h00)
    else $error("send byte outside a transmit action");

    // A delivered byte comes with ack or nack; otherwise the read fields are clear
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_valid |-> bus_action == ACT_ACK || bus_action == ACT_NACK)
    else $error("received byte without ack or nack");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !read_valid |-> read_byte == 8'h00 && read_index == '0)
    else $error("read fields set without a delivered byte");

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_i2cms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .start_accepted (start_accepted),
    .bus_action     (bus_action),
    .send_byte      (send_byte),
    .read_valid     (read_valid),
    .read_byte      (read_byte),
    .read_index     (read_index),
    .status         (status)
);

`default_nettype wire
